[design/recl_pkg.sv]
// Shared types and constants for the rotary encoder click-lock unit.
// No dependencies; imported by the top level and its checker.
package recl_pkg;

  // Number of LEDs in the thermometer bar (result field stays 8 bits wide)
  localparam int unsigned LED_COUNT = 8;
  localparam int unsigned LED_W     = 8;

  // Register reset values
  localparam logic [15:0] WINDOW_RST  = 16'd400;
  localparam logic [15:0] MIN_HOLD_RST = 16'd50;
  localparam logic [3:0]  MAX_POS_RST = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_MIN_HOLD = 2'd1;
  localparam logic [1:0] REG_MAX_POS  = 2'd2;

  // Direction tracker codes: which contact fell first
  localparam logic [1:0] EDGE_IDLE   = 2'd0;
  localparam logic [1:0] EDGE_A_LEAD = 2'd1;
  localparam logic [1:0] EDGE_B_LEAD = 2'd2;

  typedef struct packed {
    logic        contact_a;
    logic        contact_b;
    logic        button_level;
    logic [31:0] now_ms;
  } recl_in_t;

  typedef struct packed {
    logic             position_report;
    logic             click_report;
    logic             lock_changed;
    logic [3:0]       position;
    logic             lock_state;
    logic             led_update;
    logic [LED_W-1:0] led_pattern;
  } recl_out_t;

  // Thermometer code: lowest min(level, LED_COUNT) bits set
  function automatic logic [LED_W-1:0] thermometer(input logic [3:0] level);
    logic [LED_W-1:0] pat;
    pat = '0;
    for (int i = 0; i < LED_W; i++) begin
      pat[i] = (i < int'(level)) && (i < int'(LED_COUNT));
    end
    return pat;
  endfunction

endpackage

[design/rotary_encoder_click_lock_unit.sv]
// Rotary encoder click-lock unit: encoder direction/position tracking and
// button single/double click detection. Depends on recl_pkg.
//
// Usage:
//   in_valid/in_ready carry one pin sample (contacts A and B, active-low
//   button, millisecond timestamp). out_valid/out_ready carry one result per
//   sample: event flags, position, lock state and the LED thermometer bar.
//   cfg_we/cfg_index/cfg_data write the window, minimum hold and maximum
//   position registers; write them only while no sample is in flight.
// Timing:
//   A sample first lands in the input register; when it advances, the
//   encoder and button logic run, update the state and load the result
//   register, from which the result is offered on out_valid/out_data.
//   One sample per cycle is sustained while out_ready is high: the input
//   register refills in the same cycle it drains into the result register.
// Reset (rst_n low, synchronous): both registers empty, position 0,
//   unlocked, previous pin levels high, no pending click, registers at
//   window 400 ms, hold 50 ms, max position 8.
// Stall: while out_ready is low the result holds; one more sample may wait
//   in the input register, after which in_ready drops.
module rotary_encoder_click_lock_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  recl_pkg::recl_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output recl_pkg::recl_out_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import recl_pkg::*;

  // Configuration registers
  logic [15:0] window_r;
  logic [15:0] min_hold_r;
  logic [3:0]  max_pos_r;

  // Pipeline registers
  logic      in_valid_r;
  recl_in_t  in_r;
  logic      out_valid_r;
  recl_out_t out_r;
  logic      advance;

  // Block state
  logic [3:0]  pos_r,         pos_nxt;
  logic        prev_a_r,      prev_a_nxt;
  logic        prev_b_r,      prev_b_nxt;
  logic [1:0]  first_edge_r,  first_edge_nxt;
  logic        lock_r,        lock_nxt;
  logic        prev_btn_r,    prev_btn_nxt;
  logic        press_valid_r, press_valid_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] last_click_r,  last_click_nxt;
  logic        pending_r,     pending_nxt;
  recl_out_t   res_nxt;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      min_hold_r <= MIN_HOLD_RST;
      max_pos_r  <= MAX_POS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW:   window_r   <= cfg_data;
        REG_MIN_HOLD: min_hold_r <= cfg_data;
        REG_MAX_POS:  max_pos_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sample processing
  always_comb begin
    logic [4:0]  step;
    logic [31:0] hold_time;
    logic [31:0] gap;
    logic        released;

    pos_nxt         = pos_r;
    first_edge_nxt  = first_edge_r;
    lock_nxt        = lock_r;
    press_valid_nxt = press_valid_r;
    press_start_nxt = press_start_r;
    last_click_nxt  = last_click_r;
    pending_nxt     = pending_r;
    prev_a_nxt      = in_r.contact_a;
    prev_b_nxt      = in_r.contact_b;
    prev_btn_nxt    = in_r.button_level;
    res_nxt         = '0;
    step            = {1'b0, pos_r};

    // Encoder: latch the leading contact, confirm when both are high again
    if (first_edge_r == EDGE_IDLE) begin
      if (!in_r.contact_a && prev_a_r) begin
        first_edge_nxt = EDGE_A_LEAD;
      end else if (!in_r.contact_b && prev_b_r) begin
        first_edge_nxt = EDGE_B_LEAD;
      end
    end
    if (first_edge_nxt != EDGE_IDLE && in_r.contact_a && in_r.contact_b) begin
      if (!lock_r) begin
        if (first_edge_nxt == EDGE_A_LEAD) begin
          step = (pos_r != 4'd0) ? {1'b0, pos_r} - 5'd1 : 5'd0;
        end else begin
          step = {1'b0, pos_r} + 5'd1;
        end
        pos_nxt = (step > {1'b0, max_pos_r}) ? max_pos_r : step[3:0];
        res_nxt.position_report = 1'b1;
        res_nxt.led_update      = 1'b1;
      end
      first_edge_nxt = EDGE_IDLE;
    end

    // Button press timing
    if (!in_r.button_level && prev_btn_r) begin
      press_start_nxt = in_r.now_ms;
      press_valid_nxt = 1'b0;
    end
    hold_time = in_r.now_ms - press_start_nxt;
    if (!in_r.button_level && !press_valid_nxt &&
        hold_time >= {16'd0, min_hold_r}) begin
      press_valid_nxt = 1'b1;
    end

    // Valid release: second within the window toggles the lock
    released = in_r.button_level && !prev_btn_r && press_valid_r;
    gap = in_r.now_ms - last_click_r;
    if (released) begin
      press_valid_nxt = 1'b0;
      if (gap < {16'd0, window_r} && pending_r) begin
        lock_nxt             = !lock_r;
        res_nxt.lock_changed = 1'b1;
        if (lock_r) begin
          res_nxt.led_update = 1'b1;
        end
        pending_nxt = 1'b0;
      end else begin
        pending_nxt    = 1'b1;
        last_click_nxt = in_r.now_ms;
      end
    end

    // Lone click times out
    if (pending_nxt &&
        (in_r.now_ms - last_click_nxt) >= {16'd0, window_r}) begin
      res_nxt.click_report = 1'b1;
      pending_nxt          = 1'b0;
    end

    res_nxt.position    = pos_nxt;
    res_nxt.lock_state  = lock_nxt;
    res_nxt.led_pattern = thermometer(pos_nxt);
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pos_r         <= '0;
      prev_a_r      <= 1'b1;
      prev_b_r      <= 1'b1;
      first_edge_r  <= EDGE_IDLE;
      lock_r        <= 1'b0;
      prev_btn_r    <= 1'b1;
      press_valid_r <= 1'b0;
      press_start_r <= '0;
      last_click_r  <= '0;
      pending_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        pos_r         <= pos_nxt;
        prev_a_r      <= prev_a_nxt;
        prev_b_r      <= prev_b_nxt;
        first_edge_r  <= first_edge_nxt;
        lock_r        <= lock_nxt;
        prev_btn_r    <= prev_btn_nxt;
        press_valid_r <= press_valid_nxt;
        press_start_r <= press_start_nxt;
        last_click_r  <= last_click_nxt;
        pending_r     <= pending_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

endmodule

[design/recl_checker.sv]
// Port-level checker for the rotary encoder click-lock unit, with its bind.
// Depends on recl_pkg and on rotary_encoder_click_lock_unit.
module recl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input recl_pkg::recl_out_t out_data
);
  import recl_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Detent report always requests an LED rewrite
  a_report_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.position_report |-> out_data.led_update)
    else $error("position report without LED update");

  // Unlocking requests an LED rewrite
  a_unlock_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.lock_changed && !out_data.lock_state |->
      out_data.led_update)
    else $error("unlock without LED update");

  // LED bar tracks the reported position
  a_led_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.led_pattern == thermometer(out_data.position))
    else $error("LED pattern does not match position");

endmodule

bind rotary_encoder_click_lock_unit recl_checker u_recl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
